FILE: src/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types, widths and codes of the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int MAX_RANGES  = 32;
    localparam int OFFSET_BITS = 16;
    localparam int SIZE_BITS   = OFFSET_BITS + 1;
    localparam int IDX_BITS    = $clog2(MAX_RANGES);
    localparam int CNT_BITS    = $clog2(MAX_RANGES + 1);
    localparam int CAP_BITS    = 17;
    localparam int ALLOC_BITS  = 17;
    localparam int USED_BITS   = 17;
    localparam int STATUS_BITS = 3;
    localparam int RCOUNT_BITS = 6;

    localparam logic [CAP_BITS-1:0]  CAP_RESET = CAP_BITS'(65536);
    localparam logic [SIZE_BITS-1:0] SPACE_TOP = SIZE_BITS'(1) << OFFSET_BITS;

    typedef enum logic [1:0] {
        OP_RESERVE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK          = 3'd0,
        ST_NO_ROOM     = 3'd1,
        ST_NO_FIT      = 3'd2,
        ST_TABLE_FULL  = 3'd3,
        ST_NOT_IN_USE  = 3'd4,
        ST_OUT_OF_RNG  = 3'd5,
        ST_ZERO_SIZE   = 3'd6,
        ST_UNUSED      = 3'd7
    } status_t;

    typedef struct packed {
        logic                   used;
        logic [OFFSET_BITS-1:0] offset;
        logic [SIZE_BITS-1:0]   size;
    } range_t;

    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        range_t              wdata;
        logic [IDX_BITS-1:0] raddr;
    } tbl_ctl_t;

endpackage

FILE: src/ffra_div.sv
// ----------------------------------------------------------------------------
// ffra_div
// Iterative restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ffra_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ffra_pkg::OFFSET_BITS-1:0] dividend,
    input  logic [ffra_pkg::OFFSET_BITS-1:0] divisor,
    output logic                             done,
    output logic [ffra_pkg::OFFSET_BITS-1:0] remainder
);

    localparam int OB = ffra_pkg::OFFSET_BITS;
    localparam int CW = $clog2(OB + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [OB-1:0] quo_reg, quo_next;
    logic [OB-1:0] rem_reg, rem_next;
    logic [OB-1:0] div_reg, div_next;
    logic          done_reg, done_next;
    logic [OB:0]   trial;

    assign trial     = {rem_reg, quo_reg[OB-1]};
    assign done      = done_reg;
    assign remainder = rem_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CW'(OB);
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_next = {quo_reg[OB-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = OB'(trial - {1'b0, div_reg});
            else
                rem_next = OB'(trial);
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule

FILE: src/ffra_table.sv
// ----------------------------------------------------------------------------
// ffra_table
// Range table: one write port and one read port.
// ----------------------------------------------------------------------------
module ffra_table (
    input  logic               clk,
    input  ffra_pkg::tbl_ctl_t ctl,
    output ffra_pkg::range_t   rdata
);

    ffra_pkg::range_t mem [ffra_pkg::MAX_RANGES];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
            mem[ctl.waddr] <= ctl.wdata;
    end

    assign rdata = mem[ctl.raddr];

endmodule

FILE: src/first_fit_range_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// First-fit allocator over an ordered table of used and free ranges.
// ----------------------------------------------------------------------------
// Flow: a clear or unknown operation goes straight to the result; a reserve
// scans the table entry by entry and passes each free range large enough
// through the remainder unit, then on a split moves the entries behind it up
// and writes both halves; a release scans for its range, reads the right
// neighbor, writes the merged range and moves entries down when some are removed.
// Throughput: one item at a time; in_ready is high only between items.
// Reset: the table holds one free range over 65536 elements, ready one cycle
// after reset is released.
module first_fit_range_allocator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       operation,
    input  logic [ffra_pkg::ALLOC_BITS-1:0]  alloc_size,
    input  logic [ffra_pkg::OFFSET_BITS-1:0] alignment,
    input  logic [ffra_pkg::OFFSET_BITS-1:0] release_offset,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ffra_pkg::STATUS_BITS-1:0] status,
    output logic [ffra_pkg::OFFSET_BITS-1:0] granted_offset,
    output logic [ffra_pkg::USED_BITS-1:0]   used_total,
    output logic [ffra_pkg::RCOUNT_BITS-1:0] range_count,
    input  logic                             capacity_wr_en,
    input  logic [ffra_pkg::CAP_BITS-1:0]    capacity
);

    localparam int OB = ffra_pkg::OFFSET_BITS;
    localparam int SB = ffra_pkg::SIZE_BITS;
    localparam int IB = ffra_pkg::IDX_BITS;
    localparam int CB = ffra_pkg::CNT_BITS;
    localparam int UB = ffra_pkg::USED_BITS;

    // Sequencer states. Every multi-cycle step of an item is one state.
    typedef enum logic [12:0] {
        S_INIT   = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_RSCAN  = 13'b0000000000100,
        S_RDIV   = 13'b0000000001000,
        S_RFIT   = 13'b0000000010000,
        S_SHUP   = 13'b0000000100000,
        S_WR0    = 13'b0000001000000,
        S_WR1    = 13'b0000010000000,
        S_LSCAN  = 13'b0000100000000,
        S_LNEXT  = 13'b0001000000000,
        S_LMERGE = 13'b0010000000000,
        S_LSHDN  = 13'b0100000000000,
        S_RESULT = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [ffra_pkg::CAP_BITS-1:0] cap_reg;
    logic [SB-1:0]                 cap_eff;
    logic [CB-1:0]                 cnt_reg, cnt_next;
    logic [UB-1:0]                 used_reg, used_next;
    logic [CB-1:0]                 i_reg, i_next;
    logic [CB-1:0]                 k_reg, k_next;
    logic [1:0]                    rm_reg, rm_next;
    logic                          right_reg, right_next;

    logic [ffra_pkg::ALLOC_BITS-1:0] want_reg, want_next;
    logic [OB-1:0]                   al_reg, al_next;
    logic [OB-1:0]                   x_reg, x_next;
    ffra_pkg::range_t                cur_reg, cur_next;
    ffra_pkg::range_t                prev_reg, prev_next;
    ffra_pkg::range_t                nxt_reg, nxt_next;
    logic [OB-1:0]                   pad_reg, pad_next;
    logic [SB:0]                     need_reg, need_next;
    ffra_pkg::status_t               res_st_reg, res_st_next;
    logic [OB-1:0]                   res_grant_reg, res_grant_next;

    logic                          ovalid_reg;
    logic [ffra_pkg::STATUS_BITS-1:0] o_st_reg;
    logic [OB-1:0]                 o_grant_reg;
    logic [UB-1:0]                 o_used_reg;
    logic [ffra_pkg::RCOUNT_BITS-1:0] o_cnt_reg;
    logic                          load_out;

    ffra_pkg::tbl_ctl_t tctl;
    ffra_pkg::range_t   rd;

    logic                 div_start;
    logic                 div_done;
    logic [OB-1:0]        div_rem;

    // Scratch values of the combinational sequencer.
    logic [SB:0]   need_c;
    logic [SB-1:0] end_c;
    logic          left_c;
    logic [1:0]    rm_c;
    logic [CB-1:0] t_c;
    logic [SB-1:0] msize_c;
    logic [CB-1:0] src_c;

    ffra_table u_table (
        .clk   (clk),
        .ctl   (tctl),
        .rdata (rd)
    );

    // Remainder unit: offset modulo alignment for the padding.
    ffra_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (cur_next.offset),
        .divisor   (al_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Capacity of 0 acts as 1, and values above the space saturate.
    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = SB'(1);
        else if (SB'(cap_reg) > ffra_pkg::SPACE_TOP)
            cap_eff = ffra_pkg::SPACE_TOP;
        else
            cap_eff = SB'(cap_reg);
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign load_out       = (state_reg == S_RESULT) && (!ovalid_reg || out_ready);
    assign out_valid      = ovalid_reg;
    assign status         = o_st_reg;
    assign granted_offset = o_grant_reg;
    assign used_total     = o_used_reg;
    assign range_count    = o_cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        used_next      = used_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        rm_next        = rm_reg;
        right_next     = right_reg;
        want_next      = want_reg;
        al_next        = al_reg;
        x_next         = x_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        nxt_next       = nxt_reg;
        pad_next       = pad_reg;
        need_next      = need_reg;
        res_st_next    = res_st_reg;
        res_grant_next = res_grant_reg;
        div_start      = 1'b0;
        tctl           = '0;
        tctl.raddr     = i_reg[IB-1:0];
        need_c         = (SB+1)'(pad_reg) + (SB+1)'(want_reg);
        end_c          = SB'(rd.offset) + rd.size;
        left_c         = (i_reg != '0) && !prev_reg.used;
        rm_c           = 2'(left_c) + 2'(right_reg);
        t_c            = left_c ? i_reg - CB'(1) : i_reg;
        msize_c        = cur_reg.size + (left_c ? prev_reg.size : '0)
                         + (right_reg ? nxt_reg.size : '0);
        src_c          = k_reg + CB'(rm_reg);

        unique case (state_reg)
            S_INIT:
            begin
                tctl.we    = 1'b1;
                tctl.waddr = '0;
                tctl.wdata = '{used: 1'b0, offset: '0, size: cap_eff};
                cnt_next   = CB'(1);
                used_next  = '0;
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    want_next      = alloc_size;
                    al_next        = (alignment == '0) ? OB'(1) : alignment;
                    x_next         = release_offset;
                    i_next         = '0;
                    res_st_next    = ffra_pkg::ST_OK;
                    res_grant_next = '0;
                    state_next     = S_RESULT;
                    unique case (ffra_pkg::op_t'(operation))
                        ffra_pkg::OP_RESERVE:
                        begin
                            if (alloc_size == '0)
                                res_st_next = ffra_pkg::ST_ZERO_SIZE;
                            else if (SB'(used_reg) > cap_eff
                                     || SB'(alloc_size) > cap_eff - SB'(used_reg))
                                res_st_next = ffra_pkg::ST_NO_ROOM;
                            else
                                state_next = S_RSCAN;
                        end
                        ffra_pkg::OP_RELEASE:
                        begin
                            state_next = S_LSCAN;
                        end
                        ffra_pkg::OP_CLEAR:
                        begin
                            tctl.we    = 1'b1;
                            tctl.waddr = '0;
                            tctl.wdata = '{used: 1'b0, offset: '0, size: cap_eff};
                            cnt_next   = CB'(1);
                            used_next  = '0;
                        end
                        ffra_pkg::OP_NONE:
                        begin
                        end
                    endcase
                end
            end

            // Reserve: look for the first free range large enough.
            S_RSCAN:
            begin
                if (i_reg == cnt_reg)
                begin
                    res_st_next = ffra_pkg::ST_NO_FIT;
                    state_next  = S_RESULT;
                end
                else if (rd.used || rd.size < SB'(want_reg))
                begin
                    i_next = i_reg + CB'(1);
                end
                else
                begin
                    cur_next   = rd;
                    div_start  = 1'b1;
                    state_next = S_RDIV;
                end
            end

            S_RDIV:
            begin
                if (div_done)
                begin
                    pad_next   = (div_rem == '0) ? '0 : al_reg - div_rem;
                    state_next = S_RFIT;
                end
            end

            S_RFIT:
            begin
                need_next = need_c;
                if (need_c > (SB+1)'(cur_reg.size))
                begin
                    i_next     = i_reg + CB'(1);
                    state_next = S_RSCAN;
                end
                else if (need_c == (SB+1)'(cur_reg.size))
                begin
                    tctl.we        = 1'b1;
                    tctl.waddr     = i_reg[IB-1:0];
                    tctl.wdata     = '{used: 1'b1, offset: cur_reg.offset,
                                       size: cur_reg.size};
                    used_next      = used_reg + UB'(need_c);
                    res_grant_next = cur_reg.offset + pad_reg;
                    state_next     = S_RESULT;
                end
                else if (cnt_reg >= CB'(ffra_pkg::MAX_RANGES))
                begin
                    res_st_next = ffra_pkg::ST_TABLE_FULL;
                    state_next  = S_RESULT;
                end
                else
                begin
                    res_grant_next = cur_reg.offset + pad_reg;
                    k_next         = cnt_reg;
                    state_next     = S_SHUP;
                end
            end

            // Open a gap behind the split entry, moving from the top down.
            S_SHUP:
            begin
                tctl.raddr = IB'(k_reg - CB'(1));
                if (k_reg > i_reg + CB'(1))
                begin
                    tctl.we    = 1'b1;
                    tctl.waddr = k_reg[IB-1:0];
                    tctl.wdata = rd;
                    k_next     = k_reg - CB'(1);
                end
                else
                begin
                    state_next = S_WR0;
                end
            end

            S_WR0:
            begin
                tctl.we    = 1'b1;
                tctl.waddr = i_reg[IB-1:0];
                tctl.wdata = '{used: 1'b1, offset: cur_reg.offset, size: SB'(need_reg)};
                state_next = S_WR1;
            end

            S_WR1:
            begin
                tctl.we    = 1'b1;
                tctl.waddr = IB'(i_reg + CB'(1));
                tctl.wdata = '{used: 1'b0,
                               offset: OB'(SB'(cur_reg.offset) + SB'(need_reg)),
                               size: cur_reg.size - SB'(need_reg)};
                cnt_next   = cnt_reg + CB'(1);
                used_next  = used_reg + UB'(need_reg);
                state_next = S_RESULT;
            end

            // Release: find the range holding the offset, half-open match.
            S_LSCAN:
            begin
                if (i_reg == cnt_reg)
                begin
                    res_st_next = ffra_pkg::ST_OUT_OF_RNG;
                    state_next  = S_RESULT;
                end
                else if (x_reg < rd.offset || SB'(x_reg) >= end_c)
                begin
                    prev_next = rd;
                    i_next    = i_reg + CB'(1);
                end
                else if (!rd.used)
                begin
                    res_st_next = ffra_pkg::ST_NOT_IN_USE;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cur_next   = rd;
                    right_next = 1'b0;
                    state_next = (i_reg + CB'(1) < cnt_reg) ? S_LNEXT : S_LMERGE;
                end
            end

            S_LNEXT:
            begin
                tctl.raddr = IB'(i_reg + CB'(1));
                nxt_next   = rd;
                right_next = !rd.used;
                state_next = S_LMERGE;
            end

            // Write the merged free range, then close the gap it leaves.
            S_LMERGE:
            begin
                tctl.we    = 1'b1;
                tctl.waddr = t_c[IB-1:0];
                tctl.wdata = '{used: 1'b0,
                               offset: left_c ? prev_reg.offset : cur_reg.offset,
                               size: msize_c};
                used_next  = (SB'(used_reg) >= cur_reg.size)
                             ? UB'(SB'(used_reg) - cur_reg.size) : '0;
                rm_next    = rm_c;
                k_next     = t_c + CB'(1);
                state_next = (rm_c == '0) ? S_RESULT : S_LSHDN;
            end

            S_LSHDN:
            begin
                tctl.raddr = src_c[IB-1:0];
                if (src_c < cnt_reg)
                begin
                    tctl.we    = 1'b1;
                    tctl.waddr = k_reg[IB-1:0];
                    tctl.wdata = rd;
                    k_next     = k_reg + CB'(1);
                end
                else
                begin
                    cnt_next   = cnt_reg - CB'(rm_reg);
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            cap_reg    <= ffra_pkg::CAP_RESET;
            cnt_reg    <= CB'(1);
            used_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            used_reg  <= used_next;
            if (capacity_wr_en)
                cap_reg <= capacity;
            if (load_out)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        k_reg         <= k_next;
        rm_reg        <= rm_next;
        right_reg     <= right_next;
        want_reg      <= want_next;
        al_reg        <= al_next;
        x_reg         <= x_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        nxt_reg       <= nxt_next;
        pad_reg       <= pad_next;
        need_reg      <= need_next;
        res_st_reg    <= res_st_next;
        res_grant_reg <= res_grant_next;
        if (load_out)
        begin
            o_st_reg    <= res_st_reg;
            o_grant_reg <= res_grant_reg;
            o_used_reg  <= used_reg;
            o_cnt_reg   <= ffra_pkg::RCOUNT_BITS'(cnt_reg);
        end
    end

endmodule

FILE: src/ffra_checker.sv
// ----------------------------------------------------------------------------
// ffra_checker
// Port-level checks of the first-fit range allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffra_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [ffra_pkg::STATUS_BITS-1:0] status,
    input logic [ffra_pkg::OFFSET_BITS-1:0] granted_offset,
    input logic [ffra_pkg::USED_BITS-1:0]   used_total,
    input logic [ffra_pkg::RCOUNT_BITS-1:0] range_count
);

    // A waiting result holds its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
        && $stable(granted_offset) && $stable(used_total) && $stable(range_count))
        else $error("result changed while stalled");

    // A failed item never reports a granted offset.
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ffra_pkg::ST_OK |-> granted_offset == '0)
        else $error("offset granted on a failed item");

    // The table always holds between one and the maximum number of ranges.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> range_count != '0
        && range_count <= ffra_pkg::RCOUNT_BITS'(ffra_pkg::MAX_RANGES))
        else $error("range count out of bounds");

    // Used elements never exceed the space.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> used_total <= ffra_pkg::USED_BITS'(ffra_pkg::SPACE_TOP))
        else $error("used total inconsistent");

endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .granted_offset (granted_offset),
    .used_total     (used_total),
    .range_count    (range_count)
);

FILE: tb/sv/first_fit_range_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_range_allocator_tb
// Self-checking testbench for the first-fit range allocator. A behavioral
// copy of the range table predicts status, granted offset, used total and
// range count for every item. Directed items hit the corner cases first, and
// random reserve and release traffic follows under several capacity settings
// and flow-control patterns.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_tb;

    // Clock, reset and the block's ports. Every input has a known value at
    // time zero.
    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic [1:0]                       operation = ffra_pkg::OP_NONE;
    logic [ffra_pkg::ALLOC_BITS-1:0]  alloc_size = '0;
    logic [ffra_pkg::OFFSET_BITS-1:0] alignment = '0;
    logic [ffra_pkg::OFFSET_BITS-1:0] release_offset = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [ffra_pkg::STATUS_BITS-1:0] status;
    logic [ffra_pkg::OFFSET_BITS-1:0] granted_offset;
    logic [ffra_pkg::USED_BITS-1:0]   used_total;
    logic [ffra_pkg::RCOUNT_BITS-1:0] range_count;
    logic                             capacity_wr_en = 1'b0;
    logic [ffra_pkg::CAP_BITS-1:0]    capacity = ffra_pkg::CAP_RESET;

    first_fit_range_allocator i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .alloc_size     (alloc_size),
        .alignment      (alignment),
        .release_offset (release_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_offset (granted_offset),
        .used_total     (used_total),
        .range_count    (range_count),
        .capacity_wr_en (capacity_wr_en),
        .capacity       (capacity)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the range table and its counters.
    // ------------------------------------------------------------------------
    typedef struct {
        bit          used;
        int unsigned offs;
        int unsigned size;
    } span_t;

    typedef struct {
        logic [ffra_pkg::STATUS_BITS-1:0] status;
        logic [ffra_pkg::OFFSET_BITS-1:0] granted;
        logic [ffra_pkg::USED_BITS-1:0]   used;
        logic [ffra_pkg::RCOUNT_BITS-1:0] count;
    } outcome_t;

    span_t       spans[ffra_pkg::MAX_RANGES];
    int unsigned span_count;
    int unsigned elems_in_use;
    int unsigned cap_setting;
    outcome_t    pending_outcomes[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // A capacity of zero acts as one; anything above the address space
    // saturates to the full space.
    function automatic int unsigned live_capacity();
        if (cap_setting == 0)
            return 1;
        if (cap_setting > (1 << ffra_pkg::OFFSET_BITS))
            return 1 << ffra_pkg::OFFSET_BITS;
        return cap_setting;
    endfunction

    function automatic void wipe_table();
        foreach (spans[i])
            spans[i] = '{0, 0, 0};
        spans[0] = '{0, 0, live_capacity()};
        span_count = 1;
        elems_in_use = 0;
    endfunction

    function automatic void drop_span(int unsigned idx);
        for (int unsigned k = idx; k + 1 < span_count; k++)
            spans[k] = spans[k + 1];
        span_count--;
    endfunction

    // First fit: the padding in front of the aligned start is charged to the
    // used range. A split into a full table stops the scan right there.
    function automatic ffra_pkg::status_t reserve_span(int unsigned want,
                                                       int unsigned align,
                                                       output int unsigned start);
        int unsigned cap;
        int unsigned pad;
        int unsigned need;
        cap = live_capacity();
        start = 0;
        if (want == 0)
            return ffra_pkg::ST_ZERO_SIZE;
        if (align == 0)
            align = 1;
        if (elems_in_use > cap || want > cap - elems_in_use)
            return ffra_pkg::ST_NO_ROOM;
        for (int unsigned i = 0; i < span_count; i++)
        begin
            if (spans[i].used || spans[i].size < want)
                continue;
            pad  = (align - spans[i].offs % align) % align;
            need = pad + want;
            if (need > spans[i].size)
                continue;
            start = spans[i].offs + pad;
            if (need == spans[i].size)
                spans[i].used = 1;
            else
            begin
                if (span_count >= ffra_pkg::MAX_RANGES)
                begin
                    start = 0;
                    return ffra_pkg::ST_TABLE_FULL;
                end
                for (int unsigned k = span_count; k > i; k--)
                    spans[k] = spans[k - 1];
                span_count++;
                spans[i].used     = 1;
                spans[i].size     = need;
                spans[i + 1].used = 0;
                spans[i + 1].offs += need;
                spans[i + 1].size -= need;
            end
            elems_in_use += need;
            return ffra_pkg::ST_OK;
        end
        return ffra_pkg::ST_NO_FIT;
    endfunction

    // Release frees the range holding the offset and merges it with free
    // neighbors on either side.
    function automatic ffra_pkg::status_t release_span(int unsigned x);
        int unsigned s;
        bit          left;
        bit          right;
        for (int unsigned i = 0; i < span_count; i++)
        begin
            if (x < spans[i].offs || x >= spans[i].offs + spans[i].size)
                continue;
            if (!spans[i].used)
                return ffra_pkg::ST_NOT_IN_USE;
            s     = spans[i].size;
            left  = i > 0 && !spans[i - 1].used;
            right = i + 1 < span_count && !spans[i + 1].used;
            if (left && right)
            begin
                spans[i - 1].size += s + spans[i + 1].size;
                drop_span(i + 1);
                drop_span(i);
            end
            else if (left)
            begin
                spans[i - 1].size += s;
                drop_span(i);
            end
            else if (right)
            begin
                spans[i + 1].offs = spans[i].offs;
                spans[i + 1].size += s;
                drop_span(i);
            end
            else
                spans[i].used = 0;
            elems_in_use = elems_in_use >= s ? elems_in_use - s : 0;
            return ffra_pkg::ST_OK;
        end
        return ffra_pkg::ST_OUT_OF_RNG;
    endfunction

    function automatic outcome_t predict_outcome(ffra_pkg::op_t op, int unsigned want,
                                                 int unsigned align, int unsigned x);
        outcome_t    o;
        int unsigned start;
        start = 0;
        o.status = ffra_pkg::ST_OK;
        case (op)
            ffra_pkg::OP_RESERVE: o.status = reserve_span(want, align, start);
            ffra_pkg::OP_RELEASE: o.status = release_span(x);
            ffra_pkg::OP_CLEAR:   wipe_table();
            default:              ;
        endcase
        o.granted = (o.status == ffra_pkg::ST_OK) ? start[ffra_pkg::OFFSET_BITS-1:0] : '0;
        o.used    = elems_in_use[ffra_pkg::USED_BITS-1:0];
        o.count   = span_count[ffra_pkg::RCOUNT_BITS-1:0];
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Driving. Every task is entered just after a rising edge. Handshake
    // inputs are sampled at the falling edge, where they are stable, and the
    // item then moves at the next rising edge.
    // ------------------------------------------------------------------------
    task automatic send_item(ffra_pkg::op_t op, int unsigned want, int unsigned align,
                             int unsigned x);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid       <= 1'b1;
        operation      <= op;
        alloc_size     <= want[ffra_pkg::ALLOC_BITS-1:0];
        alignment      <= align[ffra_pkg::OFFSET_BITS-1:0];
        release_offset <= x[ffra_pkg::OFFSET_BITS-1:0];
        do
            @(negedge clk);
        while (!in_ready);
        pending_outcomes = {pending_outcomes, predict_outcome(op, want, align, x)};
        @(posedge clk);
    endtask

    // Drop valid and wait until every expected item has come back; the block
    // is idle once the last result is out, a few spare cycles cover the rest.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(int unsigned value);
        drain();
        capacity_wr_en <= 1'b1;
        capacity       <= value[ffra_pkg::CAP_BITS-1:0];
        @(posedge clk);
        capacity_wr_en <= 1'b0;
        cap_setting = value & 32'h1FFFF;
    endtask

    // Receiver: out_ready follows the current stall rate.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Checker: a result is taken at the edge after a falling edge that sees
    // both out_valid and out_ready high.
    always @(negedge clk)
    begin
        outcome_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result item with nothing expected");
                error_count++;
            end
            else
            begin
                e = pending_outcomes.pop_front();
                if (status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, status);
                    error_count++;
                end
                if (granted_offset !== e.granted)
                begin
                    $error("granted_offset: expected %0d, got %0d", e.granted,
                           granted_offset);
                    error_count++;
                end
                if (used_total !== e.used)
                begin
                    $error("used_total: expected %0d, got %0d", e.used, used_total);
                    error_count++;
                end
                if (range_count !== e.count)
                begin
                    $error("range_count: expected %0d, got %0d", e.count, range_count);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Corner cases at the full 65536-element capacity, then at a small one
    // where out-of-range offsets and a full table are reachable.
    task automatic test_directed();
        send_item(ffra_pkg::OP_RESERVE, 0, 0, 0);          // zero size
        send_item(ffra_pkg::OP_RESERVE, 65536, 0, 0);      // whole space, no split
        send_item(ffra_pkg::OP_RESERVE, 1, 1, 0);          // no total room left
        send_item(ffra_pkg::OP_RELEASE, 0, 0, 65535);      // last offset frees all
        send_item(ffra_pkg::OP_RESERVE, 100, 65535, 0);    // aligned start at zero
        send_item(ffra_pkg::OP_RESERVE, 10, 65535, 0);     // padding overflows the rest
        send_item(ffra_pkg::OP_RELEASE, 0, 0, 5);
        send_item(ffra_pkg::OP_RELEASE, 0, 0, 5);          // already free
        send_item(ffra_pkg::OP_NONE, 65536, 65535, 65535); // unknown operation
        send_item(ffra_pkg::OP_RESERVE, 3, 4, 0);
        send_item(ffra_pkg::OP_RESERVE, 5, 16, 0);         // padding absorbed
        send_item(ffra_pkg::OP_RELEASE, 0, 0, 16);         // merges with the free rest
        send_item(ffra_pkg::OP_CLEAR, 0, 0, 0);
        write_capacity(40);
        send_item(ffra_pkg::OP_CLEAR, 0, 0, 0);
        send_item(ffra_pkg::OP_RELEASE, 0, 0, 39);         // free range
        send_item(ffra_pkg::OP_RELEASE, 0, 0, 40);         // first offset past the end
        send_item(ffra_pkg::OP_RELEASE, 0, 0, 65535);
        for (int i = 0; i < 31; i++)
            send_item(ffra_pkg::OP_RESERVE, 1, 0, 0);      // fills the table
        send_item(ffra_pkg::OP_RESERVE, 1, 0, 0);          // split into a full table
        send_item(ffra_pkg::OP_RESERVE, 9, 0, 0);          // exact fit, no new entry
        send_item(ffra_pkg::OP_RESERVE, 1, 0, 0);          // no total room
        send_item(ffra_pkg::OP_RELEASE, 0, 0, 10);         // no free neighbor
        send_item(ffra_pkg::OP_RELEASE, 0, 0, 11);         // merges to the left
        send_item(ffra_pkg::OP_RELEASE, 0, 0, 9);          // merges to the right
        send_item(ffra_pkg::OP_RELEASE, 0, 0, 13);
        send_item(ffra_pkg::OP_RELEASE, 0, 0, 12);         // merges on both sides
        send_item(ffra_pkg::OP_RESERVE, 4, 32, 0);         // no contiguous room
    endtask

    // An offset inside one of the used ranges, or any offset when none is.
    function automatic int unsigned pick_used_offset();
        int unsigned idx[$];
        int unsigned j;
        for (int unsigned i = 0; i < span_count; i++)
            if (spans[i].used)
                idx = {idx, i};
        if (idx.size() == 0)
            return $urandom_range(65535);
        j = idx[$urandom_range(idx.size() - 1)];
        return spans[j].offs + $urandom_range(spans[j].size - 1);
    endfunction

    // Random traffic: mostly reserves of modest size and releases of live
    // ranges, with a few oversized, odd-aligned, stray and clear items.
    task automatic test_random(int n);
        int unsigned sel;
        int unsigned want;
        int unsigned align;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            case ($urandom_range(9))
                0:       want = $urandom_range(131071);
                1:       want = 0;
                2, 3:    want = $urandom_range(live_capacity());
                default: want = $urandom_range(1, 24);
            endcase
            case ($urandom_range(5))
                0:       align = $urandom_range(65535);
                1:       align = 0;
                default: align = 1 << $urandom_range(5);
            endcase
            if (sel < 50)
                send_item(ffra_pkg::OP_RESERVE, want, align, $urandom_range(65535));
            else if (sel < 88)
                send_item(ffra_pkg::OP_RELEASE, $urandom_range(131071),
                          $urandom_range(65535), pick_used_offset());
            else if (sel < 95)
                send_item(ffra_pkg::OP_RELEASE, $urandom_range(131071),
                          $urandom_range(65535), $urandom_range(65535));
            else if (sel < 98)
                send_item(ffra_pkg::OP_CLEAR, $urandom_range(131071),
                          $urandom_range(65535), $urandom_range(65535));
            else
                send_item(ffra_pkg::OP_NONE, $urandom_range(131071),
                          $urandom_range(65535), $urandom_range(65535));
        end
    endtask

    // One phase: a capacity setting, a clear to apply it, then random items
    // under the given flow-control rates.
    task automatic test_phase(int unsigned cap, int send_pct, int recv_pct, int n);
        write_capacity(cap);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        send_item(ffra_pkg::OP_CLEAR, 0, 0, 0);
        test_random(n);
    endtask

    initial
    begin
        cap_setting = ffra_pkg::CAP_RESET;
        wipe_table();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_phase(200, 0, 0, 230);
        test_phase(65536, 53, 0, 230);
        test_phase(0, 0, 53, 40);
        test_phase(131071, 35, 35, 150);
        test_phase(120, 53, 53, 230);
        drain();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Generous ceiling on the run time of roughly a thousand items.
    initial
    begin
        #60ms;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/ffra_pkg.sv
src/ffra_div.sv
src/ffra_table.sv
src/first_fit_range_allocator.sv
src/ffra_checker.sv
tb/sv/first_fit_range_allocator_tb.sv
